// ===== hdl/voice_steal_allocator_macros.svh =====
// Assertion macros used by the checker file of the voice allocator.
`ifndef VOICE_STEAL_ALLOCATOR_MACROS_SVH
`define VOICE_STEAL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define VSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("voice allocator check failed");

// Next-cycle implication, ignored while reset is high.
`define VSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("voice allocator check failed");

// Next-cycle implication that also holds through reset.
`define VSA_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("voice allocator check failed");

`endif

// ===== hdl/vsa_pkg.sv =====
// Package: sizes, action codes and voice entry layout of the voice allocator.
`default_nettype none
package vsa_pkg;
   localparam int VOICES   = 12;
   localparam int IDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int VOICE_W  = 4;
   localparam int REL_W    = 4;
   localparam int EXT_W    = (IDX_W > VOICE_W) ? IDX_W : VOICE_W;
   localparam int TIME_W   = 16;
   localparam int CHAN_W   = 8;
   localparam int GAIN_W   = 8;

   localparam logic [1:0] ACT_TRIGGER = 2'd0;
   localparam logic [1:0] ACT_TICK    = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0] start;
      logic [CHAN_W-1:0] channel;
      logic [GAIN_W-1:0] gain;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
endpackage
`default_nettype wire

// ===== hdl/vsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module vsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== hdl/voice_steal_allocator.sv =====
// Top level: voice table allocator with stealing of busy voices.
//
// Input channel req_*: one word per action. A trigger (channel, volume) asks
// for a voice, a tick advances the millisecond clock, a release frees a voice.
// Result channel rsp_*: one word per trigger with the voice index and a flag
// that is set when a playing voice was stopped to free it.
// Ticks, releases and unused actions return nothing.
// A trigger that finds an idle voice goes straight to its final step. When
// every voice is busy, the block walks the voice table in its RAM one entry a
// cycle through the single read port, then waits for the last read to come
// back before it takes the final step.
// One item is in work at a time: req_stall is high until the item is done.
// The result sits in an output register; the next item is accepted while it
// waits, and a trigger holds in its final step while rsp_stall keeps the
// register full.
// Reset frees every voice, clears the clock and drops any pending result;
// the table RAM needs no clearing, since it is read only when all voices
// have been written.
`default_nettype none
module voice_steal_allocator
   import vsa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_action,
   input  wire logic [CHAN_W-1:0]   req_channel,
   input  wire logic [GAIN_W-1:0]   req_volume,
   input  wire logic [REL_W-1:0]    req_release_voice,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [VOICE_W-1:0]       rsp_voice,
   output logic                     rsp_stolen
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [CHAN_W-1:0]   chan_ff, chan_in;
   logic [GAIN_W-1:0]   vol_ff, vol_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [VOICES-1:0]   busy_ff, busy_in;
   logic [IDX_W-1:0]    pick_ff, pick_in;
   logic                stolen_ff, stolen_in;
   logic [TIME_W-1:0]   old_age_ff, old_age_in;
   logic [IDX_W-1:0]    old_idx_ff, old_idx_in;
   logic [TIME_W-1:0]   ch_age_ff, ch_age_in;
   logic [IDX_W-1:0]    ch_idx_ff, ch_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VOICE_W-1:0]  rsp_voice_ff, rsp_voice_in;
   logic                rsp_stolen_ff, rsp_stolen_in;

   logic                req_take;
   logic                out_free;
   logic                idle_found;
   logic [IDX_W-1:0]    idle_idx;
   logic                rel_ok;
   logic [EXT_W-1:0]    rel_ext;
   logic [IDX_W-1:0]    rel_idx;
   logic [IDX_W-1:0]    final_pick;
   logic [EXT_W-1:0]    pick_ext;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [ENTRY_W-1:0]  ram_rd_data;
   entry_type           rd_entry;
   entry_type           wr_entry;
   logic [TIME_W-1:0]   age;

   vsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (VOICES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (final_pick),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (cnt_ff),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_voice  = rsp_voice_ff;
   assign rsp_stolen = rsp_stolen_ff;

   // Lowest-numbered idle voice.
   always_comb begin
      idle_idx = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            idle_idx = IDX_W'(i);
         end
      end
   end
   assign idle_found = ~&busy_ff;

   assign rel_ok  = (32'(req_release_voice) < 32'(VOICES));
   assign rel_ext = EXT_W'(req_release_voice);
   assign rel_idx = rel_ext[IDX_W-1:0];

   assign rd_entry = entry_type'(ram_rd_data);
   assign age      = now_ff - rd_entry.start;

   // A same-channel candidate is recorded only with a non-zero age, so a non-zero best age marks one.
   assign final_pick = stolen_ff ? ((ch_age_ff != '0) ? ch_idx_ff : old_idx_ff) : pick_ff;
   assign pick_ext   = EXT_W'(final_pick);

   assign wr_entry.start   = now_ff;
   assign wr_entry.channel = chan_ff;
   assign wr_entry.gain    = vol_ff;
   assign ram_wr_en        = (state_ff == ST_DONE) && out_free;
   assign ram_rd_en        = (state_ff == ST_SCAN);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = cnt_ff;
      chan_in       = chan_ff;
      vol_in        = vol_ff;
      now_in        = now_ff;
      busy_in       = busy_ff;
      pick_in       = pick_ff;
      stolen_in     = stolen_ff;
      old_age_in    = old_age_ff;
      old_idx_in    = old_idx_ff;
      ch_age_in     = ch_age_ff;
      ch_idx_in     = ch_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_voice_in  = rsp_voice_ff;
      rsp_stolen_in = rsp_stolen_ff;

      // Fold in the entry read in the previous cycle.
      if (rd_vld_ff) begin
         if (age > old_age_ff) begin
            old_age_in = age;
            old_idx_in = rd_idx_ff;
         end
         if ((rd_entry.channel == chan_ff) && (rd_entry.gain < vol_ff) &&
             (age > ch_age_ff)) begin
            ch_age_in = age;
            ch_idx_in = rd_idx_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_action)
                  ACT_TRIGGER: begin
                     chan_in    = req_channel;
                     vol_in     = req_volume;
                     pick_in    = idle_idx;
                     stolen_in  = !idle_found;
                     old_age_in = '0;
                     old_idx_in = '0;
                     ch_age_in  = '0;
                     ch_idx_in  = '0;
                     cnt_in     = '0;
                     state_in   = idle_found ? ST_DONE : ST_SCAN;
                  end
                  ACT_TICK: begin
                     now_in = now_ff + 1'b1;
                  end
                  ACT_RELEASE: begin
                     if (rel_ok) begin
                        busy_in[rel_idx] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            if (cnt_ff == IDX_W'(VOICES - 1)) begin
               state_in = ST_WAIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               busy_in[final_pick] = 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_voice_in        = pick_ext[VOICE_W-1:0];
               rsp_stolen_in       = stolen_ff;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         now_ff       <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         now_ff       <= now_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      rd_idx_ff     <= rd_idx_in;
      chan_ff       <= chan_in;
      vol_ff        <= vol_in;
      pick_ff       <= pick_in;
      stolen_ff     <= stolen_in;
      old_age_ff    <= old_age_in;
      old_idx_ff    <= old_idx_in;
      ch_age_ff     <= ch_age_in;
      ch_idx_ff     <= ch_idx_in;
      rsp_voice_ff  <= rsp_voice_in;
      rsp_stolen_ff <= rsp_stolen_in;
   end
endmodule
`default_nettype wire

// ===== hdl/vsa_checker.sv =====
// Port-level checker for the voice allocator, bound to the top level.
`default_nettype none
`include "voice_steal_allocator_macros.svh"
module vsa_checker
   import vsa_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic [1:0]          req_action,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [VOICE_W-1:0]  rsp_voice,
   input wire logic                rsp_stolen
);
   logic req_take;
   logic quiet_item;

   assign req_take   = req_valid && !req_stall;
   assign quiet_item = req_take && (req_action != ACT_TRIGGER) && !rsp_valid;

   // A stalled result word holds.
   `VSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_voice) && $stable(rsp_stolen))

   // Every voice index given out names a real voice.
   `VSA_ASSERT_NOW(a_voice_range, clock, reset, rsp_valid,
      32'(rsp_voice) < 32'(VOICES))

   // Reset drops any pending result.
   `VSA_ASSERT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid)

   // Ticks and releases never produce a result word.
   `VSA_ASSERT_NEXT(a_quiet_item, clock, reset, quiet_item, !rsp_valid)
endmodule

bind voice_steal_allocator vsa_checker u_vsa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_action        (req_action),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_voice         (rsp_voice),
   .rsp_stolen        (rsp_stolen)
);
`default_nettype wire
